// ===== hdl/rbp_pkg.sv =====
// Package for the relocatable object bit stream packer.
// Request codes, stream widths and controller/datapath command and status types.
// No dependencies.
package rbp_pkg;

  localparam int MAX_NAME_CHARS = 7;
  localparam int NAME_W         = 8 * MAX_NAME_CHARS;
  // Longest item: link head, address type, word, length field, name bytes
  localparam int ITEM_W         = 7 + 2 + 16 + 3 + NAME_W;
  localparam int STREAM_W       = 8 + ITEM_W;
  localparam int TOTAL_W        = $clog2(STREAM_W + 1);

  localparam logic [2:0] REQ_BYTE          = 3'd0;
  localparam logic [2:0] REQ_PREL          = 3'd1;
  localparam logic [2:0] REQ_DREL          = 3'd2;
  localparam logic [2:0] REQ_LINK_VAL      = 3'd3;
  localparam logic [2:0] REQ_LINK_NAME     = 3'd4;
  localparam logic [2:0] REQ_LINK_VAL_NAME = 3'd5;
  localparam logic [2:0] REQ_CLOSE         = 3'd6;

  localparam logic [3:0] CODE_END_MODULE = 4'd14;
  localparam logic [7:0] CLOSE_BYTE      = 8'h9e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  link_code;
    logic [1:0]  addr_type;
    logic [15:0] value;
    logic [2:0]  name_len;
    logic [55:0] name_chars;
  } link_item_t;

  typedef struct packed {
    logic load;    // take the accepted item into the stream register
    logic emit;    // move the top byte into the output register
    logic finish;  // park leftover bits as the partial byte
  } dp_cmd_t;

  typedef struct packed {
    logic has_byte;  // stream holds at least one complete byte
    logic out_free;  // output register can take a byte this cycle
  } dp_stat_t;

endpackage

// ===== hdl/rbp_link_if.sv =====
// Input channel interface of the bit stream packer: one link item.
// Depends on nothing.
interface rbp_link_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  link_code;
  logic [1:0]  addr_type;
  logic [15:0] value;
  logic [2:0]  name_len;
  logic [55:0] name_chars;

  modport source (output valid, req_type, link_code, addr_type, value, name_len, name_chars,
                  input ready);
  modport sink (input valid, req_type, link_code, addr_type, value, name_len, name_chars,
                output ready);
endinterface

// ===== hdl/rbp_stream_if.sv =====
// Output channel interface of the bit stream packer: one packed byte.
// Depends on nothing.
interface rbp_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== hdl/rbp_ctrl.sv =====
// Controller of the bit stream packer: sequences load, byte emission and finish.
// Depends on rbp_pkg.
module rbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rbp_pkg::dp_stat_t stat,
  output rbp_pkg::dp_cmd_t  cmd
);
  import rbp_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid && in_ready;
      end
      ST_RUN: begin
        cmd.emit   = stat.has_byte && stat.out_free;
        cmd.finish = !stat.has_byte;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_RUN;
            in_ready <= 1'b0;
          end
        end
        ST_RUN: begin
          if (!stat.has_byte) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end
endmodule

// ===== hdl/rbp_datapath.sv =====
// Datapath of the bit stream packer: item bit layout, stream shift register,
// partial byte state and output register. Depends on rbp_pkg and rbp_stream_if.
module rbp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rbp_pkg::link_item_t item,
  input  rbp_pkg::dp_cmd_t    cmd,
  output rbp_pkg::dp_stat_t   stat,
  rbp_stream_if.source        stream
);
  import rbp_pkg::*;

  logic [STREAM_W-1:0] bits;      // partial bits followed by item bits, left aligned
  logic [TOTAL_W-1:0]  total;     // valid bits in bits
  logic                is_close;
  logic [7:0]          partial_byte;
  logic [2:0]          fill;      // bits held in partial_byte (7 - bit position)
  logic [7:0]          out_byte;
  logic                out_last;
  logic                out_valid;

  logic [ITEM_W-1:0]   item_bits;
  logic [TOTAL_W-1:0]  item_len;
  logic [TOTAL_W-1:0]  total_next;
  logic [2:0]          n_chars;
  logic [NAME_W-1:0]   names;
  logic [6:0]          head;
  logic [15:0]         word;
  logic [TOTAL_W-1:0]  name_bits;

  always_comb begin
    n_chars = (item.name_len > 3'(MAX_NAME_CHARS)) ? 3'(MAX_NAME_CHARS) : item.name_len;
    // first character goes out first; characters past the length are zero
    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      names[NAME_W-1-8*i -: 8] = (i < int'(n_chars)) ? item.name_chars[8*i +: 8] : 8'h00;
    end
    head      = {1'b1, 2'b00, item.link_code};
    word      = {item.value[7:0], item.value[15:8]};
    name_bits = TOTAL_W'({n_chars, 3'b000});
    item_bits = '0;
    item_len  = '0;
    case (item.req_type)
      REQ_BYTE: begin
        item_bits = {1'b0, item.value[7:0], (ITEM_W-9)'(0)};
        item_len  = TOTAL_W'(9);
      end
      REQ_PREL, REQ_DREL: begin
        item_bits = {1'b1, (item.req_type == REQ_PREL) ? 2'b01 : 2'b10, word,
                     (ITEM_W-19)'(0)};
        item_len  = TOTAL_W'(19);
      end
      REQ_LINK_VAL: begin
        item_bits = {head, item.addr_type, word, (ITEM_W-25)'(0)};
        item_len  = TOTAL_W'(25);
      end
      REQ_LINK_NAME: begin
        item_bits = {head, n_chars, names, (ITEM_W-10-NAME_W)'(0)};
        item_len  = TOTAL_W'(10) + name_bits;
      end
      REQ_LINK_VAL_NAME: begin
        item_bits = {head, item.addr_type, word, n_chars, names};
        item_len  = TOTAL_W'(28) + name_bits;
      end
      REQ_CLOSE: begin
        item_bits = {CLOSE_BYTE, (ITEM_W-8)'(0)};
        item_len  = TOTAL_W'(8) - TOTAL_W'(fill);
      end
      default: begin
        item_bits = '0;
        item_len  = '0;
      end
    endcase
    total_next = TOTAL_W'(fill) + item_len;
    // end module pads with zeros to the byte boundary
    if (item.req_type == REQ_LINK_VAL && item.link_code == CODE_END_MODULE) begin
      total_next = (total_next + TOTAL_W'(7)) & ~TOTAL_W'(7);
    end
  end

  assign stat.has_byte = (total >= TOTAL_W'(8));
  assign stat.out_free = !out_valid || stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      fill         <= '0;
      total        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        bits     <= {partial_byte, ITEM_W'(0)} | ({item_bits, 8'h00} >> fill);
        total    <= total_next;
        is_close <= (item.req_type == REQ_CLOSE);
      end else if (cmd.emit) begin
        bits  <= bits << 8;
        total <= total - TOTAL_W'(8);
      end
      // close drops the unsent tail of its byte
      if (cmd.finish) begin
        partial_byte <= is_close ? 8'h00 : bits[STREAM_W-1 -: 8];
        fill         <= total[2:0];
      end
      if (cmd.emit) begin
        out_byte  <= bits[STREAM_W-1 -: 8];
        out_last  <= is_close;
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stream.valid    = out_valid;
  assign stream.out_byte = out_byte;
  assign stream.last     = out_last;
endmodule

// ===== hdl/rel_object_bitstream_packer.sv =====
// Top level of the relocatable object bit stream packer.
// Depends on rbp_pkg, rbp_link_if, rbp_stream_if, rbp_ctrl and rbp_datapath.
//
//   port     dir   carries
//   link     in    one link item: request kind, code, address type, value, name
//   stream   out   one packed byte, last set on the byte of a close item
//
// An item is loaded, then each completed byte (up to 11) is emitted, then the
// leftover bits are parked; the single stream shift register drains a byte per
// cycle while the output register is free to take it.
// The output register lets the next item load while the last byte waits.
// Reset (synchronous) clears the partial byte and puts the next bit at bit 7.
// A stalled output holds the stream register until the byte is taken.
module rel_object_bitstream_packer (
  input  logic        clk,
  input  logic        rst,
  rbp_link_if.sink    link,
  rbp_stream_if.source stream
);
  import rbp_pkg::*;

  link_item_t item;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign item = '{req_type:   link.req_type,
                  link_code:  link.link_code,
                  addr_type:  link.addr_type,
                  value:      link.value,
                  name_len:   link.name_len,
                  name_chars: link.name_chars};

  rbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link.valid),
    .in_ready (link.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .stream (stream)
  );

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("byte emitted into an occupied output register");

  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.emit && !cmd.finish)
    else $error("load overlaps emit or finish");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> link.ready)
    else $error("input not ready after the stream drained");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> stream.valid)
    else $error("emitted byte not presented");
endmodule
